// File: sv/polar_cap_centre_rotate_assert.svh
// Assertion macros shared by the polar cap rotation RTL.
`ifndef POLAR_CAP_CENTRE_ROTATE_ASSERT_SVH
`define POLAR_CAP_CENTRE_ROTATE_ASSERT_SVH

// same-cycle implication
`define PCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pcr_pkg.sv
// Shared types, constants and tables for the polar cap rotation block.
package pcr_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PT_W       = 96;

    localparam logic signed [21:0] PI_Q16      = 22'sd205887;
    localparam logic signed [21:0] TWO_PI_Q16  = 22'sd411775;
    localparam logic signed [21:0] HALF_PI_Q16 = 22'sd102944;
    localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032875;
    localparam logic signed [35:0] ONE_Q24      = 36'sd16777216;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 63;

    localparam logic [14:0] RADIUS_RESET = 15'd10000;
    localparam logic        ADDR_RADIUS  = 1'b0;   // word address bit of the radius register

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic signed [19:0] pmin;
        logic signed [19:0] pmax;
        logic signed [19:0] amin;
        logic signed [19:0] amax;
    } t_job;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              done;
    } t_back_ctl;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000007;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/pcr_front.sv
// Front end: accepts boundary points, stores them and tracks the angle extremes.
module pcr_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [19:0]        i_polar,
    input  logic signed [19:0]        i_azim,
    input  logic [31:0]               i_x,
    input  logic [31:0]               i_y,
    input  logic [31:0]               i_z,
    input  logic                      i_final,
    output logic                      o_job_push,
    output pcr_pkg::t_job             o_job,
    input  pcr_pkg::t_back_ctl        i_ctl,
    output logic [pcr_pkg::PT_W-1:0]  o_rd_data
);

    localparam logic [pcr_pkg::CNT_W-1:0] MAX_CNT = pcr_pkg::CNT_W'(pcr_pkg::MAX_POINTS);

    logic [pcr_pkg::CNT_W-1:0] r_count, n_count, s_count;
    logic signed [19:0] r_pmin, r_pmax, r_amin, r_amax;
    logic signed [19:0] n_pmin, n_pmax, n_amin, n_amax;
    logic signed [19:0] s_pmin, s_pmax, s_amin, s_amax;
    logic r_busy, n_busy;
    logic w_accept, w_store;

    logic [pcr_pkg::PT_W-1:0] r_mem [pcr_pkg::MAX_POINTS];
    logic [pcr_pkg::PT_W-1:0] r_rd_data;

    assign o_ready  = !r_busy;
    assign w_accept = i_valid && !r_busy;
    assign w_store  = w_accept && (r_count < MAX_CNT);
    assign o_rd_data = r_rd_data;
    assign o_job_push = w_accept && i_final;

    always_comb begin
        s_count = r_count;
        s_pmin  = r_pmin;
        s_pmax  = r_pmax;
        s_amin  = r_amin;
        s_amax  = r_amax;
        if (w_store) begin
            if (r_count == '0) begin
                s_pmin = i_polar;
                s_pmax = i_polar;
                s_amin = i_azim;
                s_amax = i_azim;
            end else begin
                if (i_polar < r_pmin) s_pmin = i_polar;
                if (i_polar > r_pmax) s_pmax = i_polar;
                if (i_azim < r_amin)  s_amin = i_azim;
                if (i_azim > r_amax)  s_amax = i_azim;
            end
            s_count = r_count + 1'b1;
        end
        o_job.count = s_count;
        o_job.pmin  = s_pmin;
        o_job.pmax  = s_pmax;
        o_job.amin  = s_amin;
        o_job.amax  = s_amax;

        n_count = s_count;
        n_pmin  = s_pmin;
        n_pmax  = s_pmax;
        n_amin  = s_amin;
        n_amax  = s_amax;
        n_busy  = r_busy;
        if (o_job_push) begin
            // job handed off; restart the point set
            n_count = '0;
            n_pmin  = '0;
            n_pmax  = '0;
            n_amin  = '0;
            n_amax  = '0;
            n_busy  = 1'b1;
        end
        if (i_ctl.done) n_busy = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pmin  <= '0;
            r_pmax  <= '0;
            r_amin  <= '0;
            r_amax  <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pmin  <= n_pmin;
            r_pmax  <= n_pmax;
            r_amin  <= n_amin;
            r_amax  <= n_amax;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) r_mem[r_count[pcr_pkg::ADDR_W-1:0]] <= {i_z, i_y, i_x};
        r_rd_data <= r_mem[i_ctl.rd_addr];
    end

endmodule

// File: sv/pcr_jobq.sv
// Two-entry job queue between front end and back end.
module pcr_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pcr_pkg::t_job o_job
);

    pcr_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
    end

endmodule

// File: sv/pcr_back.sv
// Back end: CORDIC, axis length and normalization, per-point rotation and output.
`include "polar_cap_centre_rotate_assert.svh"

module pcr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [14:0]               i_radius,
    input  logic                      i_job_valid,
    output logic                      o_job_pop,
    input  pcr_pkg::t_job             i_job,
    output pcr_pkg::t_back_ctl        o_ctl,
    input  logic [pcr_pkg::PT_W-1:0]  i_rd_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [191:0]              o_data,
    output logic                      o_degen,
    output logic                      o_last
);

    typedef enum logic [3:0] {
        B_IDLE, B_CINIT, B_CORDIC, B_CSTORE, B_SETUP, B_SQRT, B_DIVINIT,
        B_DIV, B_DIVEND, B_PREP, B_ADDR, B_READ, B_LOAD, B_ROT, B_EMIT
    } t_state;

    t_state r_state;

    logic [pcr_pkg::CNT_W-1:0]  r_count;
    logic [pcr_pkg::ADDR_W-1:0] r_idx, r_rd_addr;
    logic signed [19:0] r_ang [4];
    logic signed [32:0] r_sin [4];
    logic signed [32:0] r_cos [4];
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_neg;
    logic [1:0]         r_asel;
    logic [5:0]         r_iter;
    logic [3:0]         r_step;
    logic               r_phase;
    logic signed [71:0] r_prod;
    logic signed [35:0] r_t1, r_xc, r_yc, r_zc, r_ax, r_ay;
    logic [63:0]        r_sq, r_sn, r_res, r_bit;
    logic [34:0]        r_rem;
    logic [62:0]        r_dvd;
    logic               r_dsel;
    logic [32:0]        r_len;
    logic               r_degen;
    logic signed [35:0] r_kx, r_ky, r_c, r_s, r_omc;
    logic [31:0]        r_px, r_py, r_pz;
    logic signed [35:0] r_vx, r_vy, r_vz, r_cxp, r_cyp, r_czp, r_t, r_d, r_e;
    logic signed [37:0] r_tx, r_ty, r_acc, r_rx, r_ry, r_rz;
    logic               r_out_valid, r_out_degen, r_out_last, r_done;
    logic [191:0]       r_out_data;

    logic signed [35:0] m_a, m_b;
    logic signed [33:0] w_dx, w_dy, w_at;
    logic signed [35:0] w_sh36;
    logic signed [37:0] w_sh38;
    logic [21:0]        w_fold;
    logic [63:0]        w_rb;
    logic [34:0]        w_rem2;
    logic               w_ge;
    logic signed [35:0] w_absx, w_absy, w_q, w_qs;
    logic               w_out_free, w_last, w_emit;

    function automatic logic [21:0] cordic_fold(input logic signed [19:0] a);
        logic signed [21:0] w;
        logic neg;
        w   = 22'(a);
        neg = 1'b0;
        if (w > pcr_pkg::PI_Q16)       w = w - pcr_pkg::TWO_PI_Q16;
        else if (w < -pcr_pkg::PI_Q16) w = w + pcr_pkg::TWO_PI_Q16;
        if (w > pcr_pkg::HALF_PI_Q16) begin
            w   = w - pcr_pkg::PI_Q16;
            neg = 1'b1;
        end else if (w < -pcr_pkg::HALF_PI_Q16) begin
            w   = w + pcr_pkg::PI_Q16;
            neg = 1'b1;
        end
        return {neg, w[20:0]};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [37:0] v);
        logic [31:0] r;
        if (v > 38'sd2147483647)       r = 32'h7FFFFFFF;
        else if (v < -38'sd2147483648) r = 32'h80000000;
        else                           r = v[31:0];
        return r;
    endfunction

    assign w_dx   = r_cy >>> r_iter[4:0];
    assign w_dy   = r_cx >>> r_iter[4:0];
    assign w_at   = $signed({2'b00, pcr_pkg::atan_q30(r_iter[4:0])});
    assign w_fold = cordic_fold(r_ang[r_asel]);
    assign w_sh36 = $signed(r_prod[59:24]);
    assign w_sh38 = $signed(r_prod[61:24]);
    assign w_rb   = r_res + r_bit;
    assign w_rem2 = {r_rem[33:0], r_dvd[62]};
    assign w_ge   = (w_rem2 >= {2'b00, r_len});
    assign w_absx = (r_ax < 0) ? -r_ax : r_ax;
    assign w_absy = (r_ay < 0) ? -r_ay : r_ay;
    assign w_q    = $signed(r_dvd[35:0]);
    assign w_qs   = ((r_dsel ? r_ay : r_ax) < 0) ? -w_q : w_q;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_last = (pcr_pkg::CNT_W'(r_idx) + 1'b1) == r_count;
    assign w_emit = (r_state == B_EMIT) && w_out_free;

    assign o_job_pop     = (r_state == B_IDLE) && i_job_valid;
    assign o_ctl.rd_addr = r_rd_addr;
    assign o_ctl.done    = r_done;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_degen = r_out_degen;
    assign o_last  = r_out_last;

    // shared multiplier operands
    always_comb begin
        m_a = '0;
        m_b = '0;
        if (r_state == B_SETUP) begin
            case (r_step)
                4'd0: begin m_a = 36'(r_sin[0]); m_b = 36'(r_cos[1]); end
                4'd1: begin m_a = $signed({21'd0, i_radius}); m_b = r_t1; end
                4'd2: begin m_a = 36'(r_sin[0]); m_b = 36'(r_sin[1]); end
                4'd3: begin m_a = $signed({21'd0, i_radius}); m_b = r_t1; end
                4'd4: begin m_a = $signed({21'd0, i_radius}); m_b = 36'(r_cos[0]); end
                4'd5: begin
                    m_a = 36'(r_sin[0]);
                    m_b = 36'(r_cos[2]) - 36'(r_cos[3]);
                end
                4'd6: begin
                    m_a = 36'(r_sin[0]);
                    m_b = 36'(r_sin[2]) - 36'(r_sin[3]);
                end
                4'd7: begin m_a = w_absx; m_b = w_absx; end
                4'd8: begin m_a = w_absy; m_b = w_absy; end
                default: ;
            endcase
        end else if (r_state == B_ROT) begin
            case (r_step)
                4'd0:  begin m_a = r_ky;  m_b = r_vz;  end
                4'd1:  begin m_a = r_kx;  m_b = r_vz;  end
                4'd2:  begin m_a = r_kx;  m_b = r_vy;  end
                4'd3:  begin m_a = r_ky;  m_b = r_vx;  end
                4'd4:  begin m_a = r_kx;  m_b = r_vx;  end
                4'd5:  begin m_a = r_ky;  m_b = r_vy;  end
                4'd6:  begin m_a = r_d;   m_b = r_kx;  end
                4'd7:  begin m_a = r_e;   m_b = r_omc; end
                4'd8:  begin m_a = r_d;   m_b = r_ky;  end
                4'd9:  begin m_a = r_e;   m_b = r_omc; end
                4'd10: begin m_a = r_vx;  m_b = r_c;   end
                4'd11: begin m_a = r_cxp; m_b = r_s;   end
                4'd12: begin m_a = r_vy;  m_b = r_c;   end
                4'd13: begin m_a = r_cyp; m_b = r_s;   end
                4'd14: begin m_a = r_vz;  m_b = r_c;   end
                default: begin m_a = r_czp; m_b = r_s; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            r_rd_addr   <= '0;
        end else begin
            r_done <= w_emit && w_last;
            if (w_emit)       r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_count  <= i_job.count;
                        r_ang[0] <= 20'((21'(i_job.pmin) + 21'(i_job.pmax)) >>> 1);
                        r_ang[1] <= 20'((21'(i_job.amin) + 21'(i_job.amax)) >>> 1);
                        r_ang[2] <= i_job.amax;
                        r_ang[3] <= i_job.amin;
                        r_asel   <= 2'd0;
                        r_state  <= B_CINIT;
                    end
                end
                B_CINIT: begin
                    r_neg   <= w_fold[21];
                    r_cz    <= 34'($signed(w_fold[20:0])) <<< 14;
                    r_cx    <= pcr_pkg::CORDIC_K_Q30;
                    r_cy    <= '0;
                    r_iter  <= '0;
                    r_state <= B_CORDIC;
                end
                B_CORDIC: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                        r_cz <= r_cz - w_at;
                    end else begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                        r_cz <= r_cz + w_at;
                    end
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == 6'(pcr_pkg::CORDIC_STEPS - 1)) r_state <= B_CSTORE;
                end
                B_CSTORE: begin
                    r_sin[r_asel] <= r_neg ? 33'(-r_cy) : 33'(r_cy);
                    r_cos[r_asel] <= r_neg ? 33'(-r_cx) : 33'(r_cx);
                    if (r_asel == 2'd3) begin
                        r_step  <= '0;
                        r_phase <= 1'b0;
                        r_state <= B_SETUP;
                    end else begin
                        r_asel  <= r_asel + 1'b1;
                        r_state <= B_CINIT;
                    end
                end
                B_SETUP: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_step <= r_step + 1'b1;
                        case (r_step)
                            4'd0: r_t1 <= r_prod[65:30];
                            4'd1: r_xc <= r_prod[49:14];
                            4'd2: r_t1 <= r_prod[65:30];
                            4'd3: r_yc <= r_prod[49:14];
                            4'd4: r_zc <= r_prod[49:14];
                            4'd5: r_ax <= r_prod[65:30];
                            4'd6: r_ay <= r_prod[65:30];
                            4'd7: r_sq <= r_prod[63:0];
                            default: begin
                                r_sn    <= r_sq + r_prod[63:0];
                                r_res   <= '0;
                                r_bit   <= 64'd1 << 62;
                                r_iter  <= '0;
                                r_state <= B_SQRT;
                            end
                        endcase
                    end
                end
                B_SQRT: begin
                    if (r_sn >= w_rb) begin
                        r_sn  <= r_sn - w_rb;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == 6'(pcr_pkg::SQRT_STEPS - 1)) r_state <= B_DIVINIT;
                end
                B_DIVINIT: begin
                    r_len  <= r_res[32:0];
                    r_rem  <= '0;
                    r_dvd  <= {w_absx[32:0], 30'd0};
                    r_dsel <= 1'b0;
                    r_iter <= '0;
                    r_degen <= (r_res == '0);
                    r_state <= (r_res == '0) ? B_PREP : B_DIV;
                end
                B_DIV: begin
                    r_rem  <= w_ge ? (w_rem2 - {2'b00, r_len}) : w_rem2;
                    r_dvd  <= {r_dvd[61:0], w_ge};
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == 6'(pcr_pkg::DIV_STEPS - 1)) r_state <= B_DIVEND;
                end
                B_DIVEND: begin
                    if (!r_dsel) begin
                        r_kx    <= w_qs >>> 6;
                        r_dsel  <= 1'b1;
                        r_rem   <= '0;
                        r_dvd   <= {w_absy[32:0], 30'd0};
                        r_iter  <= '0;
                        r_state <= B_DIV;
                    end else begin
                        r_ky    <= w_qs >>> 6;
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    r_c     <= 36'(r_cos[0]) >>> 6;
                    r_s     <= -(36'(r_sin[0]) >>> 6);
                    r_omc   <= pcr_pkg::ONE_Q24 - (36'(r_cos[0]) >>> 6);
                    r_idx   <= '0;
                    r_state <= B_ADDR;
                end
                B_ADDR: begin
                    r_rd_addr <= r_idx;
                    r_state   <= B_READ;
                end
                B_READ: r_state <= B_LOAD;
                B_LOAD: begin
                    r_px <= i_rd_data[31:0];
                    r_py <= i_rd_data[63:32];
                    r_pz <= i_rd_data[95:64];
                    r_vx <= 36'($signed(i_rd_data[31:0]))  - r_xc;
                    r_vy <= 36'($signed(i_rd_data[63:32])) - r_yc;
                    r_vz <= 36'($signed(i_rd_data[95:64])) - r_zc;
                    r_rx <= 38'($signed(i_rd_data[31:0]));
                    r_ry <= 38'($signed(i_rd_data[63:32]));
                    r_rz <= 38'($signed(i_rd_data[95:64]));
                    r_step  <= '0;
                    r_phase <= 1'b0;
                    r_state <= r_degen ? B_EMIT : B_ROT;
                end
                B_ROT: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_step <= r_step + 1'b1;
                        case (r_step)
                            4'd0:  r_cxp <= w_sh36;
                            4'd1:  r_cyp <= -w_sh36;
                            4'd2:  r_t   <= w_sh36;
                            4'd3:  r_czp <= r_t - w_sh36;
                            4'd4:  r_t   <= w_sh36;
                            4'd5:  r_d   <= r_t + w_sh36;
                            4'd6:  r_e   <= w_sh36;
                            4'd7:  r_tx  <= w_sh38;
                            4'd8:  r_e   <= w_sh36;
                            4'd9:  r_ty  <= w_sh38;
                            4'd10: r_acc <= w_sh38;
                            4'd11: r_rx  <= r_acc + w_sh38 + r_tx + 38'(r_xc);
                            4'd12: r_acc <= w_sh38;
                            4'd13: r_ry  <= r_acc + w_sh38 + r_ty + 38'(r_yc);
                            4'd14: r_acc <= w_sh38;
                            default: begin
                                r_rz    <= r_acc + w_sh38 + 38'(r_zc);
                                r_state <= B_EMIT;
                            end
                        endcase
                    end
                end
                B_EMIT: begin
                    if (w_out_free) begin
                        r_out_data  <= {sat32(r_rz), sat32(r_ry), sat32(r_rx),
                                        r_pz, r_py, r_px};
                        r_out_degen <= r_degen;
                        r_out_last  <= w_last;
                        if (w_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= B_ADDR;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `PCR_ASSERT_NXT(a_emit_loads, i_clk, i_rst_n, (r_state == B_EMIT) && w_out_free, r_out_valid, "emit did not load the output register")
    `PCR_ASSERT_IMP(a_degen_pass, i_clk, i_rst_n, r_out_valid && r_out_degen, r_out_data[191:96] == r_out_data[95:0], "degenerate beat is not unrotated")
    `PCR_ASSERT_IMP(a_done_last, i_clk, i_rst_n, r_done, r_out_valid && r_out_last, "done without a last beat")

endmodule

// File: sv/polar_cap_centre_rotate.sv
// Top level of the polar cap centre rotation block.
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid/tready              tdata points, tlast final point
//  m_axis    out  tvalid/tready              tdata coords, tuser degenerate, tlast last
//  apb       in   psel/penable/pwrite        stellar radius at address 0
//
// Points load at one beat per cycle, while no pass is running, into a 64-entry store.
// The final point starts a pass: CORDIC sine and cosine of four angles, setup multiplies,
// a square root and two divisions (skipped when degenerate), then for each stored point
// a memory read plus 16 steps of the shared multiplier (only the read when degenerate).
// Input is held off from the final beat until the last result has been produced.
// Synchronous active-low reset; the output register lets the pass run one beat ahead.
module polar_cap_centre_rotate (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,   // polar_angle, azimuth_angle, pos_x, pos_y, pos_z
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [191:0]  m_axis_tdata,   // orig_x, orig_y, orig_z, rot_x, rot_y, rot_z
    output logic          m_axis_tuser,   // degenerate
    output logic          m_axis_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [14:0]         r_radius;
    logic                w_push, w_full, w_jvalid, w_pop;
    pcr_pkg::t_job       w_job_in, w_job_out;
    pcr_pkg::t_back_ctl  w_ctl;
    logic [pcr_pkg::PT_W-1:0] w_rd_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pcr_pkg::ADDR_RADIUS) ? {17'd0, r_radius} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= pcr_pkg::RADIUS_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == pcr_pkg::ADDR_RADIUS)) begin
            r_radius <= pwdata[14:0];
        end
    end

    pcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_polar    (s_axis_tdata[19:0]),
        .i_azim     (s_axis_tdata[39:20]),
        .i_x        (s_axis_tdata[71:40]),
        .i_y        (s_axis_tdata[103:72]),
        .i_z        (s_axis_tdata[135:104]),
        .i_final    (s_axis_tlast),
        .o_job_push (w_push),
        .o_job      (w_job_in),
        .i_ctl      (w_ctl),
        .o_rd_data  (w_rd_data)
    );

    pcr_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_jvalid),
        .o_job   (w_job_out)
    );

    pcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radius    (r_radius),
        .i_job_valid (w_jvalid && !w_full | w_jvalid),
        .o_job_pop   (w_pop),
        .i_job       (w_job_out),
        .o_ctl       (w_ctl),
        .i_rd_data   (w_rd_data),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_degen     (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule
